FILE: rtl/core/selective_hue_keep_pixel_core_assert.svh
// ----------------------------------------------------------------------------
// selective hue keep assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_HUE_KEEP_PIXEL_CORE_ASSERT_SVH
`define SELECTIVE_HUE_KEEP_PIXEL_CORE_ASSERT_SVH

// same-cycle implication
`define SHK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/shk_pkg.sv
// ----------------------------------------------------------------------------
// shk_pkg
// shared types, constants and hue helper for the selective hue keep core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shk_pkg;

  localparam int CH_W       = 8;
  localparam int PCT_W      = 7;
  localparam int HUE_V_W    = 11;
  localparam int PROD_W     = 15;
  localparam int GRAY_NUM_W = 17;
  localparam int GRAY_DIV   = 100;
  // gray /100 as multiply by ceil(2^24/100) and shift, exact for 17 bit sums
  localparam int GRAY_RCP_SH = 24;
  localparam int GRAY_RCP    = ((1 << GRAY_RCP_SH) + GRAY_DIV - 1) / GRAY_DIV;
  localparam int GRAY_RCP_W  = 18;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] CFG_MIX_RED   = 3'd0;
  localparam logic [2:0] CFG_MIX_GREEN = 3'd1;
  localparam logic [2:0] CFG_MIX_BLUE  = 3'd2;
  localparam logic [2:0] CFG_KEEP_EN   = 3'd3;
  localparam logic [2:0] CFG_TOL       = 3'd4;
  localparam logic [2:0] CFG_TGT_RED   = 3'd5;
  localparam logic [2:0] CFG_TGT_GREEN = 3'd6;
  localparam logic [2:0] CFG_TGT_BLUE  = 3'd7;

  typedef enum logic [1:0] {
    REGION_KEEP  = 2'd0,
    REGION_BLEND = 2'd1,
    REGION_GRAY  = 2'd2
  } region_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // hue sector numerator and 6*delta denominator
  typedef struct packed {
    logic [HUE_V_W-1:0] num;
    logic [HUE_V_W-1:0] den;
  } hue_prep_t;

  function automatic hue_prep_t hue_prep(input logic [CH_W-1:0] r,
                                         input logic [CH_W-1:0] g,
                                         input logic [CH_W-1:0] b);
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] dl;
    logic [11:0]     dl6;
    logic [11:0]     v;
    hue_prep_t       p;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl  = mx - mn;
    dl6 = 12'(dl) * 12'd6;
    if (r == mx) begin
      v = (g >= b) ? 12'(g - b) : dl6 - 12'(b - g);
    end else if (g == mx) begin
      v = 12'(dl) * 12'd2 + 12'(b) - 12'(r);
    end else begin
      v = 12'(dl) * 12'd4 + 12'(r) - 12'(g);
    end
    if (dl == '0) begin
      p.num = '0;
      p.den = HUE_V_W'(1);
    end else begin
      p.num = v[HUE_V_W-1:0];
      p.den = dl6[HUE_V_W-1:0];
    end
    return p;
  endfunction

endpackage

FILE: rtl/core/shk_in_if.sv
// ----------------------------------------------------------------------------
// shk_in_if
// pixel input channel, valid/ready with rgb payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shk_in_if;
  logic                    valid;
  logic                    ready;
  logic [shk_pkg::CH_W-1:0] pix_red;
  logic [shk_pkg::CH_W-1:0] pix_green;
  logic [shk_pkg::CH_W-1:0] pix_blue;

  modport source (output valid, output pix_red, output pix_green, output pix_blue,
                  input ready);
  modport sink (input valid, input pix_red, input pix_green, input pix_blue,
                output ready);
endinterface

FILE: rtl/core/shk_out_if.sv
// ----------------------------------------------------------------------------
// shk_out_if
// result channel, valid/ready with rgb and region payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shk_out_if;
  logic                    valid;
  logic                    ready;
  logic [shk_pkg::CH_W-1:0] out_red;
  logic [shk_pkg::CH_W-1:0] out_green;
  logic [shk_pkg::CH_W-1:0] out_blue;
  logic [1:0]              region;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output region, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input region, output ready);
endinterface

FILE: rtl/core/shk_div_pipe.sv
// ----------------------------------------------------------------------------
// shk_div_pipe
// pipelined restoring divider, one quotient bit per stage, several lanes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shk_div_pipe #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 16,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [LANES-1:0][NUM_W-1:0]       num_i,
  input  logic [LANES-1:0][DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              out_vld,
  output logic [LANES-1:0][QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]                 side_o
);

  // quotient must fit QUO_W bits, so the top of num is already below den
  logic [LANES-1:0][NUM_W-1:0] num_r  [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] den_r  [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] rem_r  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_r  [QUO_W];
  logic [SIDE_W-1:0]           side_r [QUO_W];
  logic [QUO_W-1:0]            vld_r;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [LANES-1:0][NUM_W-1:0] num_in;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [LANES-1:0][DEN_W-1:0] rem_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic [SIDE_W-1:0]           side_in;
    logic                        vld_in;
    logic [LANES-1:0][DEN_W:0]   trial;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0][DEN_W-1:0] rem_nxt;
    logic [LANES-1:0][QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_head
      always_comb begin
        num_in  = num_i;
        den_in  = den_i;
        side_in = side_i;
        vld_in  = in_vld;
        quo_in  = '0;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = DEN_W'(num_i[l] >> QUO_W);
        end
      end
    end else begin : g_body
      always_comb begin
        num_in  = num_r[k-1];
        den_in  = den_r[k-1];
        rem_in  = rem_r[k-1];
        quo_in  = quo_r[k-1];
        side_in = side_r[k-1];
        vld_in  = vld_r[k-1];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]   = {rem_in[l], num_in[l][QUO_W-1-k]};
        ge[l]      = trial[l] >= {1'b0, den_in[l]};
        rem_nxt[l] = ge[l] ? DEN_W'(trial[l] - {1'b0, den_in[l]}) : DEN_W'(trial[l]);
        quo_nxt[l] = {quo_in[l][QUO_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k]  <= num_in;
        den_r[k]  <= den_in;
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign quo_o   = quo_r[QUO_W-1];
  assign side_o  = side_r[QUO_W-1];

endmodule

FILE: rtl/core/selective_hue_keep_pixel_core.sv
// ----------------------------------------------------------------------------
// selective_hue_keep_pixel_core
// Pixel stream filter: gray level from weighted channels, hue kept near a
// target hue, blended in a band around it, gray elsewhere.
// Usage:
//   in_ch takes one rgb pixel per transaction, out_ch gives one result pixel
//   and its region code per transaction, in the same order.
//   The cfg_ APB port holds eight registers at byte address 4*index; write
//   them only while no transaction is in flight.
// Throughput: one pixel per clock, the pipeline is fully stalled as a whole.
// Stages: input, products and hue terms, gray sum, the bit-per-stage
//   hue sector divider, hue distance, blend products, blend quotients,
//   output; gray /100 and blend /half circle are reciprocal multiplies.
// Reset: synchronous, active low; clears all valid bits and loads the
//   register defaults (weights 30/59/11, keep hue off).
// Stall: when the output holds a transaction that is not taken, every stage
//   freezes and in_ch.ready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "selective_hue_keep_pixel_core_assert.svh"

module selective_hue_keep_pixel_core #(
  parameter int HUE_FULL_CIRCLE = 1440
) (
  input  logic                               clk,
  input  logic                               rst_n,
  shk_in_if.sink                             in_ch,
  shk_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [shk_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [shk_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [shk_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CH_W     = shk_pkg::CH_W;
  localparam int PCT_W    = shk_pkg::PCT_W;
  localparam int HV_W     = shk_pkg::HUE_V_W;
  localparam int HALF     = HUE_FULL_CIRCLE / 2;
  localparam int HUE_W    = $clog2(HUE_FULL_CIRCLE);
  localparam int Q1_W     = HUE_W;
  localparam int HNUM_W   = HV_W + $clog2(HUE_FULL_CIRCLE + 1);
  localparam int D1_NUM_W = HNUM_W;
  localparam int HD_W     = $clog2(HALF + 1);
  localparam int CMP_W    = HD_W + PCT_W + 1;
  localparam int BNUM_W   = CH_W + HD_W;
  localparam int GR_SH    = shk_pkg::GRAY_RCP_SH;
  localparam int GPROD_W  = shk_pkg::GRAY_NUM_W + shk_pkg::GRAY_RCP_W;
  // blend /half circle as multiply by ceil(2^32/half) and shift, exact for
  // numerators below 256*half
  localparam int BLEND_SH = 32;
  localparam longint unsigned BLEND_RCP =
    ((64'd1 << BLEND_SH) + 64'(HALF) - 64'd1) / 64'(HALF);
  localparam int BRCP_W   = $clog2(BLEND_RCP + 1);
  localparam int BPROD_W  = BNUM_W + BRCP_W;

  // ---------------------------------------------------------------- config
  logic [PCT_W-1:0] mix_red_r, mix_green_r, mix_blue_r, tol_r;
  logic             keep_en_r;
  logic [CH_W-1:0]  tgt_red_r, tgt_green_r, tgt_blue_r;
  logic [CMP_W-1:0] tolh_r;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_red_r   <= PCT_W'(30);
      mix_green_r <= PCT_W'(59);
      mix_blue_r  <= PCT_W'(11);
      keep_en_r   <= 1'b0;
      tol_r       <= '0;
      tgt_red_r   <= '0;
      tgt_green_r <= '0;
      tgt_blue_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        shk_pkg::CFG_MIX_RED:   mix_red_r   <= cfg_pwdata[PCT_W-1:0];
        shk_pkg::CFG_MIX_GREEN: mix_green_r <= cfg_pwdata[PCT_W-1:0];
        shk_pkg::CFG_MIX_BLUE:  mix_blue_r  <= cfg_pwdata[PCT_W-1:0];
        shk_pkg::CFG_KEEP_EN:   keep_en_r   <= cfg_pwdata[0];
        shk_pkg::CFG_TOL:       tol_r       <= cfg_pwdata[PCT_W-1:0];
        shk_pkg::CFG_TGT_RED:   tgt_red_r   <= cfg_pwdata[CH_W-1:0];
        shk_pkg::CFG_TGT_GREEN: tgt_green_r <= cfg_pwdata[CH_W-1:0];
        shk_pkg::CFG_TGT_BLUE:  tgt_blue_r  <= cfg_pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // tolerance scaled to the half circle, settles long before the next pixel
  always_ff @(posedge clk) begin
    tolh_r <= CMP_W'(tol_r) * CMP_W'(HALF);
  end

  always_comb begin
    case (cfg_idx)
      shk_pkg::CFG_MIX_RED:   cfg_prdata = 32'(mix_red_r);
      shk_pkg::CFG_MIX_GREEN: cfg_prdata = 32'(mix_green_r);
      shk_pkg::CFG_MIX_BLUE:  cfg_prdata = 32'(mix_blue_r);
      shk_pkg::CFG_KEEP_EN:   cfg_prdata = 32'(keep_en_r);
      shk_pkg::CFG_TOL:       cfg_prdata = 32'(tol_r);
      shk_pkg::CFG_TGT_RED:   cfg_prdata = 32'(tgt_red_r);
      shk_pkg::CFG_TGT_GREEN: cfg_prdata = 32'(tgt_green_r);
      shk_pkg::CFG_TGT_BLUE:  cfg_prdata = 32'(tgt_blue_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  // whole pipeline moves together unless the output transaction is held
  logic out_valid_r;
  logic en;

  assign en          = !(out_valid_r && !out_ch.ready);
  assign in_ch.ready = en;

  // stage 1: input register
  logic              s1_vld_r;
  shk_pkg::rgb_t     s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix_r <= '{red: in_ch.pix_red, green: in_ch.pix_green, blue: in_ch.pix_blue};
    end
  end

  // stage 2: weight products and hue sector terms for pixel and target
  logic                         s2_vld_r;
  shk_pkg::rgb_t                s2_pix_r;
  logic [shk_pkg::PROD_W-1:0]   s2_pr_r, s2_pg_r, s2_pb_r;
  shk_pkg::hue_prep_t           s2_hp_r, s2_tp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pix_r <= s1_pix_r;
      s2_pr_r  <= shk_pkg::PROD_W'(mix_red_r) * shk_pkg::PROD_W'(s1_pix_r.red);
      s2_pg_r  <= shk_pkg::PROD_W'(mix_green_r) * shk_pkg::PROD_W'(s1_pix_r.green);
      s2_pb_r  <= shk_pkg::PROD_W'(mix_blue_r) * shk_pkg::PROD_W'(s1_pix_r.blue);
      s2_hp_r  <= shk_pkg::hue_prep(s1_pix_r.red, s1_pix_r.green, s1_pix_r.blue);
      s2_tp_r  <= shk_pkg::hue_prep(tgt_red_r, tgt_green_r, tgt_blue_r);
    end
  end

  // stage 3: gray sum and hue numerators scaled to the circle
  logic                              s3_vld_r;
  shk_pkg::rgb_t                     s3_pix_r;
  logic [shk_pkg::GRAY_NUM_W-1:0]    s3_gsum_r;
  logic [HNUM_W-1:0]                 s3_hnum_r, s3_tnum_r;
  logic [HV_W-1:0]                   s3_hden_r, s3_tden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pix_r  <= s2_pix_r;
      s3_gsum_r <= shk_pkg::GRAY_NUM_W'(s2_pr_r) + shk_pkg::GRAY_NUM_W'(s2_pg_r)
                   + shk_pkg::GRAY_NUM_W'(s2_pb_r);
      s3_hnum_r <= HNUM_W'(s2_hp_r.num) * HNUM_W'(HUE_FULL_CIRCLE);
      s3_tnum_r <= HNUM_W'(s2_tp_r.num) * HNUM_W'(HUE_FULL_CIRCLE);
      s3_hden_r <= s2_hp_r.den;
      s3_tden_r <= s2_tp_r.den;
    end
  end

  // gray level /100 by reciprocal, saturated at 255, rides the divider side
  logic [GPROD_W-1:0]       gray_prod;
  logic [CH_W-1:0]          gray_s3;

  always_comb begin
    gray_prod = GPROD_W'(s3_gsum_r) * GPROD_W'(shk_pkg::GRAY_RCP);
    gray_s3   = (gray_prod[GPROD_W-1:GR_SH+CH_W] != '0) ? {CH_W{1'b1}}
                                                        : gray_prod[GR_SH +: CH_W];
  end

  // divider 1: lane 0 pixel hue, lane 1 target hue
  logic [1:0][D1_NUM_W-1:0] d1_num;
  logic [1:0][HV_W-1:0]     d1_den;
  logic [1:0][Q1_W-1:0]     d1_quo;
  logic                     d1_vld;
  logic [4*CH_W-1:0]        d1_side;
  shk_pkg::rgb_t            d1_pix;
  logic [CH_W-1:0]          d1_gray;

  assign d1_num[0] = D1_NUM_W'(s3_hnum_r);
  assign d1_num[1] = D1_NUM_W'(s3_tnum_r);
  assign d1_den[0] = s3_hden_r;
  assign d1_den[1] = s3_tden_r;

  shk_div_pipe #(
    .LANES (2),
    .NUM_W (D1_NUM_W),
    .DEN_W (HV_W),
    .QUO_W (Q1_W),
    .SIDE_W(4 * CH_W)
  ) u_div_hue (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s3_vld_r),
    .num_i  (d1_num),
    .den_i  (d1_den),
    .side_i ({s3_pix_r, gray_s3}),
    .out_vld(d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side)
  );

  assign d1_pix  = d1_side[4*CH_W-1 -: 3*CH_W];
  assign d1_gray = d1_side[CH_W-1:0];

  // stage 4: circular hue distance, region decision
  logic [Q1_W-1:0]     diff;
  logic [HD_W-1:0]     d_nxt;
  logic [CMP_W-1:0]    d100;
  shk_pkg::region_t    region_nxt;

  always_comb begin
    diff     = (d1_quo[0] >= d1_quo[1]) ? d1_quo[0] - d1_quo[1] : d1_quo[1] - d1_quo[0];
    if (diff > Q1_W'(HALF)) begin
      d_nxt = HD_W'(Q1_W'(HUE_FULL_CIRCLE) - diff);
    end else begin
      d_nxt = HD_W'(diff);
    end
    d100 = CMP_W'(d_nxt) * CMP_W'(100);
    if (!keep_en_r) begin
      region_nxt = shk_pkg::REGION_GRAY;
    end else if (d100 <= tolh_r) begin
      region_nxt = shk_pkg::REGION_KEEP;
    end else if (d100 > {tolh_r[CMP_W-2:0], 1'b0} || tolh_r[CMP_W-1]) begin
      // doubled tolerance overflows only when it is far above any distance
      region_nxt = tolh_r[CMP_W-1] ? shk_pkg::REGION_BLEND : shk_pkg::REGION_GRAY;
    end else begin
      region_nxt = shk_pkg::REGION_BLEND;
    end
  end

  logic                s4_vld_r;
  shk_pkg::rgb_t       s4_pix_r;
  logic [CH_W-1:0]     s4_gray_r;
  logic [HD_W-1:0]     s4_d_r;
  shk_pkg::region_t    s4_region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pix_r    <= d1_pix;
      s4_gray_r   <= d1_gray;
      s4_d_r      <= d_nxt;
      s4_region_r <= region_nxt;
    end
  end

  // stage 5: blend weight products
  logic                     s5_vld_r;
  shk_pkg::rgb_t            s5_pix_r;
  logic [CH_W-1:0]          s5_gray_r;
  shk_pkg::region_t         s5_region_r;
  logic [3:0][BNUM_W-1:0]   s5_prod_r;
  logic [HD_W-1:0]          wt_keep;

  assign wt_keep = HD_W'(HALF) - s4_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_pix_r     <= s4_pix_r;
      s5_gray_r    <= s4_gray_r;
      s5_region_r  <= s4_region_r;
      s5_prod_r[0] <= BNUM_W'(s4_pix_r.red) * BNUM_W'(wt_keep);
      s5_prod_r[1] <= BNUM_W'(s4_pix_r.green) * BNUM_W'(wt_keep);
      s5_prod_r[2] <= BNUM_W'(s4_pix_r.blue) * BNUM_W'(wt_keep);
      s5_prod_r[3] <= BNUM_W'(s4_gray_r) * BNUM_W'(s4_d_r);
    end
  end

  // stage 6: four products over the half circle by reciprocal
  logic [3:0][BPROD_W-1:0]  blend_prod;
  logic                     s6_vld_r;
  shk_pkg::rgb_t            s6_pix_r;
  logic [CH_W-1:0]          s6_gray_r;
  shk_pkg::region_t         s6_region_r;
  logic [3:0][CH_W-1:0]     s6_quo_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      blend_prod[i] = BPROD_W'(s5_prod_r[i]) * BPROD_W'(BLEND_RCP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pix_r    <= s5_pix_r;
      s6_gray_r   <= s5_gray_r;
      s6_region_r <= s5_region_r;
      for (int i = 0; i < 4; i++) begin
        s6_quo_r[i] <= blend_prod[i][BLEND_SH +: CH_W];
      end
    end
  end

  // output stage: sum blend terms and pick the result
  logic [CH_W:0]        sum_r_nxt, sum_g_nxt, sum_b_nxt;
  shk_pkg::rgb_t        res_nxt;
  shk_pkg::rgb_t        out_pix_r;
  shk_pkg::region_t     out_region_r;

  always_comb begin
    sum_r_nxt = (CH_W+1)'(s6_quo_r[0]) + (CH_W+1)'(s6_quo_r[3]);
    sum_g_nxt = (CH_W+1)'(s6_quo_r[1]) + (CH_W+1)'(s6_quo_r[3]);
    sum_b_nxt = (CH_W+1)'(s6_quo_r[2]) + (CH_W+1)'(s6_quo_r[3]);
    case (s6_region_r)
      shk_pkg::REGION_KEEP:  res_nxt = s6_pix_r;
      shk_pkg::REGION_BLEND: res_nxt = '{red:   sum_r_nxt[CH_W-1:0],
                                         green: sum_g_nxt[CH_W-1:0],
                                         blue:  sum_b_nxt[CH_W-1:0]};
      default:               res_nxt = '{red: s6_gray_r, green: s6_gray_r,
                                         blue: s6_gray_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r    <= res_nxt;
      out_region_r <= s6_region_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_pix_r.red;
  assign out_ch.out_green = out_pix_r.green;
  assign out_ch.out_blue  = out_pix_r.blue;
  assign out_ch.region    = out_region_r;

  // ---------------------------------------------------------------- checks
  `SHK_ASSERT_IMP(a_region_legal, out_valid_r,
    out_region_r == shk_pkg::REGION_KEEP || out_region_r == shk_pkg::REGION_BLEND ||
    out_region_r == shk_pkg::REGION_GRAY, "region code out of range")
  `SHK_ASSERT_IMP(a_gray_uniform, out_valid_r && out_region_r == shk_pkg::REGION_GRAY,
    out_pix_r.red == out_pix_r.green && out_pix_r.green == out_pix_r.blue,
    "gray result with unequal channels")
  `SHK_ASSERT_IMP(a_keep_off_gray, out_valid_r && !keep_en_r,
    out_region_r == shk_pkg::REGION_GRAY, "hue kept while keep hue is off")
  `SHK_ASSERT_NXT(a_freeze_holds, !en, out_valid_r,
    "held transaction vanished during freeze")

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective hue keep pixel core. Pixels go in
// through a valid/ready driver, and results come back through a monitor. Each
// result is checked against an in-bench model of the gray level and of the
// blend by hue distance, under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int HUE_CIRCLE = 1440;
  localparam int HALF_CIRCLE = HUE_CIRCLE / 2;
  localparam int PIPE_DRAIN = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    shk_pkg::region_t region;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  shk_in_if  in_ch ();
  shk_out_if out_ch ();

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  selective_hue_keep_pixel_core #(.HUE_FULL_CIRCLE(HUE_CIRCLE)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // local copy of the register file
  int unsigned mix_r, mix_g, mix_b, keep_en, tol_pct, tgt_r, tgt_g, tgt_b;

  shk_pkg::rgb_t pixel_queue[$];
  pix_result_t expected_pixels[$];
  int          fail_count = 0;
  int          result_count = 0;
  int          cycle_count = 0;
  int unsigned region_seen[3] = '{0, 0, 0};
  bit          idle_enable = 1'b1;
  bit          hold_input = 1'b0;
  int          send_gap = 0;
  int          sink_gap = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hue on the circle, gray counts as zero
  function automatic int unsigned hue_angle(int unsigned r, int unsigned g, int unsigned b);
    int mx, mn, dl, v;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    if (dl == 0) return 0;
    if (r == mx) v = int'(g) - int'(b);
    else if (g == mx) v = 2 * dl + int'(b) - int'(r);
    else v = 4 * dl + int'(r) - int'(g);
    if (v < 0) v += 6 * dl;
    return (v * HUE_CIRCLE) / (6 * dl);
  endfunction

  function automatic pix_result_t keep_hue_pixel(shk_pkg::rgb_t p);
    int unsigned gray, d, tolh, hp, ht;
    int unsigned ch[3];
    pix_result_t res;
    ch[0] = p.red; ch[1] = p.green; ch[2] = p.blue;
    gray = (mix_r * ch[0] + mix_g * ch[1] + mix_b * ch[2]) / 100;
    if (gray > 255) gray = 255;
    res.region = shk_pkg::REGION_GRAY;
    if (keep_en != 0) begin
      hp = hue_angle(ch[0], ch[1], ch[2]);
      ht = hue_angle(tgt_r, tgt_g, tgt_b);
      d = (hp > ht) ? hp - ht : ht - hp;
      if (d > HALF_CIRCLE) d = HUE_CIRCLE - d;
      tolh = tol_pct * HALF_CIRCLE;
      if (d * 100 <= tolh) begin
        res.region = shk_pkg::REGION_KEEP;
      end else if (d * 100 <= 2 * tolh) begin
        res.region = shk_pkg::REGION_BLEND;
        for (int i = 0; i < 3; i++)
          ch[i] = (ch[i] * (HALF_CIRCLE - d)) / HALF_CIRCLE + (gray * d) / HALF_CIRCLE;
      end
    end
    if (res.region == shk_pkg::REGION_GRAY) begin
      ch[0] = gray; ch[1] = gray; ch[2] = gray;
    end
    res.red = ch[0][7:0];
    res.green = ch[1][7:0];
    res.blue = ch[2][7:0];
    return res;
  endfunction

  // driver: predicts at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.pix_red <= '0;
      in_ch.pix_green <= '0;
      in_ch.pix_blue <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_pixels.push_back(keep_hue_pixel({in_ch.pix_red, in_ch.pix_green,
                                                   in_ch.pix_blue}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 2);
          in_ch.valid <= 1'b0;
        end else if (!hold_input && pixel_queue.size() > 0) begin
          shk_pkg::rgb_t p;
          p = pixel_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.pix_red <= p.red;
          in_ch.pix_green <= p.green;
          in_ch.pix_blue <= p.blue;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got, want);
    fail_count++;
  endtask

  // monitor and result side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          pix_result_t want;
          want = expected_pixels.pop_front();
          if (out_ch.out_red !== want.red) report_mismatch("red", out_ch.out_red, want.red);
          if (out_ch.out_green !== want.green)
            report_mismatch("green", out_ch.out_green, want.green);
          if (out_ch.out_blue !== want.blue)
            report_mismatch("blue", out_ch.out_blue, want.blue);
          if (out_ch.region !== want.region)
            report_mismatch("region", out_ch.region, want.region);
          region_seen[want.region]++;
        end
        result_count++;
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // apb write: setup then access, mirror updated at the same edge
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      shk_pkg::CFG_MIX_RED:   mix_r = value & 32'h7f;
      shk_pkg::CFG_MIX_GREEN: mix_g = value & 32'h7f;
      shk_pkg::CFG_MIX_BLUE:  mix_b = value & 32'h7f;
      shk_pkg::CFG_KEEP_EN:   keep_en = value & 32'h1;
      shk_pkg::CFG_TOL:       tol_pct = value & 32'h7f;
      shk_pkg::CFG_TGT_RED:   tgt_r = value & 32'hff;
      shk_pkg::CFG_TGT_GREEN: tgt_g = value & 32'hff;
      default:                tgt_b = value & 32'hff;
    endcase
  endtask

  // wait for the pipe to empty before touching registers
  task automatic drain_pipe();
    while (pixel_queue.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic set_config(int unsigned mr, int unsigned mg, int unsigned mb,
                            int unsigned en, int unsigned tol,
                            int unsigned tr, int unsigned tg, int unsigned tb_val);
    drain_pipe();
    write_reg(shk_pkg::CFG_MIX_RED, mr);
    write_reg(shk_pkg::CFG_MIX_GREEN, mg);
    write_reg(shk_pkg::CFG_MIX_BLUE, mb);
    write_reg(shk_pkg::CFG_KEEP_EN, en);
    write_reg(shk_pkg::CFG_TOL, tol);
    write_reg(shk_pkg::CFG_TGT_RED, tr);
    write_reg(shk_pkg::CFG_TGT_GREEN, tg);
    write_reg(shk_pkg::CFG_TGT_BLUE, tb_val);
  endtask

  // mostly pixels near the target hue so every region is reached
  task automatic queue_random(int count);
    shk_pkg::rgb_t p;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        p = shk_pkg::rgb_t'(24'($urandom));
      end else begin
        p.red = 8'(int'(tgt_r) + int'($urandom_range(0, 80)) - 40);
        p.green = 8'(int'(tgt_g) + int'($urandom_range(0, 80)) - 40);
        p.blue = 8'(int'(tgt_b) + int'($urandom_range(0, 80)) - 40);
      end
      pixel_queue.push_back(p);
    end
  endtask

  initial begin
    mix_r = 30; mix_g = 59; mix_b = 11; keep_en = 0; tol_pct = 0;
    tgt_r = 0; tgt_g = 0; tgt_b = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset defaults, extremes, gray pixels and each primary
    pixel_queue.push_back('{8'd0, 8'd0, 8'd0});
    pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
    pixel_queue.push_back('{8'd255, 8'd0, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd255, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd0, 8'd255});
    set_config(30, 59, 11, 1, 20, 255, 0, 0);
    pixel_queue.push_back('{8'd255, 8'd0, 8'd0});
    pixel_queue.push_back('{8'd255, 8'd40, 8'd0});
    pixel_queue.push_back('{8'd255, 8'd0, 8'd40});
    pixel_queue.push_back('{8'd255, 8'd120, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd255, 8'd255});
    pixel_queue.push_back('{8'd128, 8'd128, 8'd128});
    pixel_queue.push_back('{8'd170, 8'd85, 8'd85});
    // weights above 100 saturate, tolerance above 100 keeps everything
    set_config(127, 127, 127, 1, 127, 128, 128, 128);
    pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
    pixel_queue.push_back('{8'd1, 8'd2, 8'd3});
    pixel_queue.push_back('{8'd0, 8'd255, 8'd0});
    set_config(0, 0, 0, 1, 0, 0, 0, 0);
    pixel_queue.push_back('{8'd0, 8'd0, 8'd0});
    pixel_queue.push_back('{8'd200, 8'd10, 8'd10});
    pixel_queue.push_back('{8'd7, 8'd7, 8'd7});

    // mid stream, hold off the sender until every expected result is back
    drain_pipe();
    queue_random(20);
    while (pixel_queue.size() > 10) @(posedge clk);
    hold_input = 1'b1;
    while (in_ch.valid || expected_pixels.size() > 0) @(posedge clk);
    hold_input = 1'b0;
    drain_pipe();

    // random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      set_config($urandom_range(0, 110), $urandom_range(0, 110), $urandom_range(0, 110),
                 (ph % 4 != 3), $urandom_range(0, 100),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      queue_random(130);
    end
    // last part with no idling at all
    drain_pipe();
    idle_enable = 1'b0;
    queue_random(40);
    drain_pipe();

    $display("covered %0d results: keep %0d, blend %0d, gray %0d", result_count,
             region_seen[0], region_seen[1], region_seen[2]);
    $display("weights, tolerance and target hue varied across 12 register settings");
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/shk_pkg.sv
rtl/core/shk_in_if.sv
rtl/core/shk_out_if.sv
rtl/core/shk_div_pipe.sv
rtl/core/selective_hue_keep_pixel_core.sv
test/tb.sv
